>>> design/sme_pkg.sv
// package for the stack machine executor: opcodes, status codes, fsm states
// no dependencies
`timescale 1ns / 1ps
package sme_pkg;

  localparam int unsigned DataDepthDef   = 256;
  localparam int unsigned ReturnDepthDef = 64;
  localparam int unsigned VarCountDef    = 256;
  localparam int unsigned ProgDepthDef   = 4096;

  localparam int unsigned ModeW = 5;
  localparam int unsigned DataW = 32;
  localparam int unsigned PcW   = 13;
  localparam int unsigned RetW  = 12;
  localparam int unsigned StW   = 4;
  localparam int unsigned DepW  = 9;

  typedef enum logic [ModeW-1:0] {
    OP_NOP = 5'd0, OP_PUSH = 5'd1, OP_POP = 5'd2, OP_DUP = 5'd3, OP_SWAP = 5'd4,
    OP_ADD = 5'd5, OP_SUB = 5'd6, OP_MUL = 5'd7, OP_DIV = 5'd8, OP_CMP = 5'd9,
    OP_GRT = 5'd10, OP_LSS = 5'd11, OP_JMP = 5'd12, OP_CALL = 5'd13,
    OP_STORE = 5'd14, OP_LOAD = 5'd15, OP_DISP = 5'd16, OP_RET = 5'd17
  } op_e;

  typedef enum logic [StW-1:0] {
    ST_OK = 4'd0, ST_OVER = 4'd1, ST_UNDER = 4'd2, ST_DIVZ = 4'd3, ST_JUMP = 4'd4,
    ST_RFULL = 4'd5, ST_VAR = 4'd6, ST_HALT = 4'd7, ST_END = 4'd8
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE, S_READ, S_DIV, S_EXEC, S_SWAP, S_OUT
  } state_e;

  localparam int unsigned CfgStart = 0;
  localparam int unsigned CfgLen   = 1;

  // controller to datapath
  typedef struct packed {
    logic capture;    // latch incoming item, issue reads
    logic div_start;
    logic exec;       // commit instruction
    logic wr2;        // second stack write of a swap
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic need_div;
    logic div_done;
    logic need_swap;
  } stat_t;

endpackage

>>> design/sme_ram.sv
// generic single write, single read ram with registered read data
// no dependencies
`timescale 1ns / 1ps
module sme_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end
endmodule

>>> design/sme_div.sv
// iterative signed divider, one quotient bit per cycle, truncating
// uses sme_pkg
`timescale 1ns / 1ps
module sme_div import sme_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [DataW-1:0] num_i,
  input  logic [DataW-1:0] den_i,
  output logic             done_o,
  output logic [DataW-1:0] quot_o
);
  logic [DataW-1:0] rem_q, rem_d, quo_q, quo_d, den_q, den_d;
  logic [5:0] cnt_q, cnt_d;
  logic neg_q, neg_d, busy_q, busy_d;
  logic [DataW:0] trial;
  logic [DataW-1:0] shifted;

  always_comb begin
    rem_d = rem_q; quo_d = quo_q; den_d = den_q; cnt_d = cnt_q;
    neg_d = neg_q; busy_d = busy_q;
    shifted = {rem_q[DataW-2:0], quo_q[DataW-1]};
    trial = {1'b0, shifted} - {1'b0, den_q};
    if (start_i) begin
      // work on magnitudes
      quo_d  = num_i[DataW-1] ? (~num_i + 1'b1) : num_i;
      den_d  = den_i[DataW-1] ? (~den_i + 1'b1) : den_i;
      neg_d  = num_i[DataW-1] ^ den_i[DataW-1];
      rem_d  = '0;
      cnt_d  = 6'(DataW);
      busy_d = 1'b1;
    end else if (busy_q) begin
      // restoring step
      if (!trial[DataW]) begin
        rem_d = trial[DataW-1:0];
        quo_d = {quo_q[DataW-2:0], 1'b1};
      end else begin
        rem_d = shifted;
        quo_d = {quo_q[DataW-2:0], 1'b0};
      end
      cnt_d = cnt_q - 6'd1;
      if (cnt_q == 6'd1) busy_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d; quo_q <= quo_d; den_q <= den_d; neg_q <= neg_d;
  end

  assign done_o = !busy_q && !start_i;
  assign quot_o = neg_q ? (~quo_q + 1'b1) : quo_q;
endmodule

>>> design/sme_ctrl.sv
// sequencing state machine: fetch operands, optional divide, commit, optional swap write, output
// uses sme_pkg
`timescale 1ns / 1ps
module sme_ctrl import sme_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  in_valid_i,
  output logic  in_ready_o,
  output logic  out_valid_o,
  input  logic  out_ready_i,
  input  stat_t stat_i,
  output cmd_t  cmd_o
);
  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= S_IDLE;
    else         state_q <= state_d;
  end

  // next state and commands
  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d = S_READ;
        end
      end
      S_READ: begin
        if (stat_i.need_div) begin
          cmd_o.div_start = 1'b1;
          state_d = S_DIV;
        end else begin
          cmd_o.exec = 1'b1;
          state_d = stat_i.need_swap ? S_SWAP : S_OUT;
        end
      end
      S_DIV: begin
        if (stat_i.div_done) state_d = S_EXEC;
      end
      S_EXEC: begin
        cmd_o.exec = 1'b1;
        state_d = S_OUT;
      end
      // swap writes the lower entry in the cycle after the commit
      S_SWAP: begin
        cmd_o.wr2 = 1'b1;
        state_d = S_OUT;
      end
      S_OUT: begin
        out_valid_o = 1'b1;
        in_ready_o  = out_ready_i;
        if (out_ready_i) begin
          if (in_valid_i) begin
            cmd_o.capture = 1'b1;
            state_d = S_READ;
          end else begin
            state_d = S_IDLE;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end
endmodule

>>> design/sme_dp.sv
// datapath: stacks, variable store, pc, status and result registers
// uses sme_pkg, sme_ram, sme_div
`timescale 1ns / 1ps
module sme_dp import sme_pkg::*; #(
  parameter int unsigned DataDepth   = DataDepthDef,
  parameter int unsigned ReturnDepth = ReturnDepthDef,
  parameter int unsigned VarCount    = VarCountDef,
  parameter int unsigned ProgDepth   = ProgDepthDef
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic             cfg_idx_i,
  input  logic [PcW-1:0]   cfg_data_i,
  input  logic [ModeW-1:0] mode_i,
  input  logic [DataW-1:0] operand_i,
  input  cmd_t             cmd_i,
  output stat_t            stat_o,
  output logic [PcW-1:0]   next_pc_o,
  output logic [StW-1:0]   status_o,
  output logic [1:0]       display_kind_o,
  output logic [DataW-1:0] display_value_o,
  output logic [DepW-1:0]  depth_now_o
);
  localparam int unsigned DAw = $clog2(DataDepth);
  localparam int unsigned DCw = $clog2(DataDepth + 1);
  localparam int unsigned RAw = (ReturnDepth > 1) ? $clog2(ReturnDepth) : 1;
  localparam int unsigned RCw = $clog2(ReturnDepth + 1);
  localparam int unsigned VAw = (VarCount > 1) ? $clog2(VarCount) : 1;
  localparam int unsigned PLw = $clog2(ProgDepth + 1);

  // configuration and architectural state
  logic [PcW-1:0]  plen_q;
  logic [PLw+1:0]  pc_q;
  logic [DCw-1:0]  dep_q;
  logic [RCw-1:0]  rdep_q;
  logic [StW-1:0]  stop_q;
  logic [VarCount-1:0] vvalid_q;
  logic [ModeW-1:0] mode_q;
  logic [DataW-1:0] opnd_q;
  logic [DataW-1:0] swap_q;

  // two data-stack copies give top and second from the same read
  logic            top_we, ds_we;
  logic [DAw-1:0]  top_wa, ds_wa, top_ra, sec_ra;
  logic [DataW-1:0] top_wd, ds_wd, top_rd, sec_rd;
  logic [DataW-1:0] var_rd;
  logic [RetW-1:0]  ret_rd;
  logic             ret_we, var_we;
  logic [RAw-1:0]   ret_ra;
  logic [VAw-1:0]   var_idx;
  logic [DataW-1:0] quot;
  logic             div_done;
  logic [DataW-1:0] top_v, sec_v, var_v;
  logic [PLw+1:0]   plen_eff;

  // read addresses from the stack depths and the incoming item
  logic [DCw-1:0] dm1, dm2;
  logic [RCw-1:0] rm1;
  assign dm1 = dep_q - 1'b1;
  assign dm2 = dep_q - 2'd2;
  assign rm1 = rdep_q - 1'b1;
  assign top_ra = dm1[DAw-1:0];
  assign sec_ra = dm2[DAw-1:0];
  assign ret_ra = rm1[RAw-1:0];
  assign var_idx = cmd_i.capture ? operand_i[VAw-1:0] : opnd_q[VAw-1:0];

  // one write port shared by both copies; a swap puts its second write in the next cycle
  assign ds_we = top_we || cmd_i.wr2;
  assign ds_wa = cmd_i.wr2 ? sec_ra : top_wa;
  assign ds_wd = cmd_i.wr2 ? swap_q : top_wd;

  sme_ram #(.Width(DataW), .Depth(DataDepth)) u_dsa (
    .clk_i, .we_i(ds_we), .waddr_i(ds_wa), .wdata_i(ds_wd),
    .raddr_i(top_ra), .rdata_o(top_rd));
  sme_ram #(.Width(DataW), .Depth(DataDepth)) u_dsb (
    .clk_i, .we_i(ds_we), .waddr_i(ds_wa), .wdata_i(ds_wd),
    .raddr_i(sec_ra), .rdata_o(sec_rd));
  sme_ram #(.Width(RetW), .Depth(ReturnDepth)) u_rs (
    .clk_i, .we_i(ret_we), .waddr_i(rdep_q[RAw-1:0]), .wdata_i(pc_q[RetW-1:0]),
    .raddr_i(ret_ra), .rdata_o(ret_rd));
  sme_ram #(.Width(DataW), .Depth(VarCount)) u_vs (
    .clk_i, .we_i(var_we), .waddr_i(var_idx), .wdata_i(top_v),
    .raddr_i(var_idx), .rdata_o(var_rd));

  assign top_v = top_rd;
  assign sec_v = sec_rd;
  assign var_v = vvalid_q[var_idx] ? var_rd : '0;

  sme_div u_div (
    .clk_i, .rst_ni, .start_i(cmd_i.div_start), .num_i(sec_v), .den_i(top_v),
    .done_o(div_done), .quot_o(quot));

  // effective length
  assign plen_eff = ((PLw+2)'(plen_q) > (PLw+2)'(ProgDepth)) ? (PLw+2)'(ProgDepth)
                                                             : (PLw+2)'(plen_q);

  assign stat_o.need_div = (mode_q == OP_DIV) && (stop_q == ST_OK)
                           && (pc_q < plen_eff) && (dep_q >= DCw'(2))
                           && (top_v != '0);
  assign stat_o.div_done = div_done;

  // execute
  logic [PLw+1:0] nxt;
  logic [StW-1:0] st;
  logic [1:0] dk;
  logic [DataW-1:0] dv, res, prod;
  logic [DCw-1:0] dep_n;
  logic [RCw-1:0] rdep_n;
  logic signed [DataW-1:0] ts, ss;
  logic tgt_bad, var_bad, skip, swap_go;
  always_comb begin
    ts = top_v; ss = sec_v;
    nxt = pc_q + 1'b1;
    st = ST_OK; dk = 2'd0; dv = '0;
    dep_n = dep_q; rdep_n = rdep_q;
    top_we = 1'b0; top_wa = dep_q[DAw-1:0]; top_wd = opnd_q;
    ret_we = 1'b0; var_we = 1'b0;
    res = '0; skip = 1'b0; swap_go = 1'b0;
    prod = sec_v * top_v;
    tgt_bad = opnd_q[DataW-1] || ({1'b0, opnd_q} > {{(DataW-PLw-1){1'b0}}, plen_eff});
    var_bad = opnd_q[DataW-1] || (opnd_q >= DataW'(VarCount));
    case (mode_q)
      OP_PUSH: begin
        if (dep_q >= DCw'(DataDepth)) st = ST_OVER;
        else begin top_we = 1'b1; dep_n = dep_q + 1'b1; end
      end
      OP_POP: begin
        if (opnd_q[DataW-1] || opnd_q > DataW'(dep_q)) st = ST_UNDER;
        else dep_n = dep_q - opnd_q[DCw-1:0];
      end
      OP_DUP: begin
        if (dep_q == '0) st = ST_UNDER;
        else if (dep_q >= DCw'(DataDepth)) st = ST_OVER;
        else begin top_we = 1'b1; top_wd = top_v; dep_n = dep_q + 1'b1; end
      end
      OP_SWAP: begin
        if (dep_q < DCw'(2)) st = ST_UNDER;
        else begin
          top_we = 1'b1; top_wa = top_ra; top_wd = sec_v;
          swap_go = 1'b1;
        end
      end
      OP_ADD, OP_SUB, OP_MUL, OP_DIV: begin
        if (dep_q < DCw'(2)) st = ST_UNDER;
        else if (mode_q == OP_DIV && top_v == '0) st = ST_DIVZ;
        else begin
          case (mode_q)
            OP_ADD:  res = sec_v + top_v;
            OP_SUB:  res = sec_v - top_v;
            OP_MUL:  res = prod;
            default: res = quot;
          endcase
          top_we = 1'b1; top_wa = sec_ra; top_wd = res;
          dep_n = dep_q - 1'b1;
        end
      end
      OP_CMP, OP_GRT, OP_LSS: begin
        if (dep_q < DCw'(2)) st = ST_UNDER;
        else begin
          case (mode_q)
            OP_CMP:  skip = ts != ss;
            OP_GRT:  skip = ts > ss;
            default: skip = ts < ss;
          endcase
          if (skip) nxt = pc_q + 2'd2;
        end
      end
      OP_JMP: begin
        if (tgt_bad) st = ST_JUMP;
        else nxt = opnd_q[PLw+1:0];
      end
      OP_CALL: begin
        if (rdep_q >= RCw'(ReturnDepth)) st = ST_RFULL;
        else if (tgt_bad) st = ST_JUMP;
        else begin ret_we = 1'b1; rdep_n = rdep_q + 1'b1; nxt = opnd_q[PLw+1:0]; end
      end
      OP_STORE: begin
        if (var_bad) st = ST_VAR;
        else if (dep_q == '0) st = ST_UNDER;
        else begin var_we = 1'b1; dep_n = dep_q - 1'b1; end
      end
      OP_LOAD: begin
        if (var_bad) st = ST_VAR;
        else if (dep_q >= DCw'(DataDepth)) st = ST_OVER;
        else begin top_we = 1'b1; top_wd = var_v; dep_n = dep_q + 1'b1; end
      end
      OP_DISP: begin
        if (opnd_q == '0 || opnd_q == DataW'(1)) begin
          if (dep_q == '0) st = ST_UNDER;
          else begin dk = (opnd_q == '0) ? 2'd1 : 2'd2; dv = top_v; end
        end
      end
      OP_RET: begin
        if (rdep_q == '0) st = ST_HALT;
        else begin rdep_n = rm1; nxt = (PLw+2)'(ret_rd) + 1'b1; end
      end
      default: ;
    endcase
    if (st != ST_OK) begin
      nxt = pc_q; dk = 2'd0; dv = '0;
      dep_n = dep_q; rdep_n = rdep_q;
      top_we = 1'b0; ret_we = 1'b0; var_we = 1'b0; swap_go = 1'b0;
    end else if (nxt >= plen_eff) begin
      st = ST_END;
    end
    // stopped or already past end: nothing runs
    if (stop_q != ST_OK || pc_q >= plen_eff) begin
      st = (stop_q != ST_OK) ? stop_q : ST_END;
      nxt = pc_q; dk = 2'd0; dv = '0;
      dep_n = dep_q; rdep_n = rdep_q;
      top_we = 1'b0; ret_we = 1'b0; var_we = 1'b0; swap_go = 1'b0;
    end
    if (!cmd_i.exec) begin
      top_we = 1'b0; ret_we = 1'b0; var_we = 1'b0;
    end
  end

  assign stat_o.need_swap = swap_go;

  // state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      plen_q <= '0; pc_q <= '0; dep_q <= '0; rdep_q <= '0;
      stop_q <= ST_OK; vvalid_q <= '0;
    end else begin
      if (cfg_we_i && cfg_idx_i == 1'(CfgStart)) begin
        pc_q <= (PLw+2)'(cfg_data_i[RetW-1:0]);
      end
      if (cfg_we_i && cfg_idx_i == 1'(CfgLen)) plen_q <= cfg_data_i;
      if (cmd_i.exec) begin
        stop_q <= st;
        if (st == ST_OK || st == ST_END) pc_q <= nxt;
        dep_q <= dep_n; rdep_q <= rdep_n;
        if (var_we) vvalid_q[var_idx] <= 1'b1;
      end
    end
  end

  // item and result registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      mode_q <= mode_i;
      opnd_q <= operand_i;
    end
    if (cmd_i.exec) begin
      swap_q          <= top_v;
      next_pc_o       <= nxt[PcW-1:0];
      status_o        <= st;
      display_kind_o  <= dk;
      display_value_o <= dv;
      depth_now_o     <= DepW'(dep_n);
    end
  end
endmodule

>>> design/stack_machine_execute.sv
// channel   | signals                                   | direction
// in        | in_valid_i, in_ready_o, mode_i, operand_i | input item
// out       | out_valid_o, out_ready_i, result fields   | result item
// cfg       | cfg_we_i, cfg_idx_i, cfg_data_i           | register writes
// an item is handled in order: operand read from the stack rams, then commit, then
// output handoff; div runs the bit-serial divider before the commit, swap adds a
// second stack write after the commit
// reset clears depths, status, pc, program length and variable valid bits; stack contents are not cleared
// a stalled result holds the block, next item is taken as the result leaves
// top level: controller and datapath; uses sme_pkg, sme_ctrl, sme_dp
`timescale 1ns / 1ps
module stack_machine_execute import sme_pkg::*; #(
  parameter int unsigned DataDepth   = DataDepthDef,
  parameter int unsigned ReturnDepth = ReturnDepthDef,
  parameter int unsigned VarCount    = VarCountDef,
  parameter int unsigned ProgDepth   = ProgDepthDef
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic             cfg_idx_i,
  input  logic [PcW-1:0]   cfg_data_i,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic [ModeW-1:0] mode_i,
  input  logic signed [DataW-1:0] operand_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic [PcW-1:0]   next_pc_o,
  output logic [StW-1:0]   status_o,
  output logic [1:0]       display_kind_o,
  output logic signed [DataW-1:0] display_value_o,
  output logic [DepW-1:0]  depth_now_o
);
  cmd_t  cmd;
  stat_t stat;

  sme_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .out_valid_o, .out_ready_i,
    .stat_i(stat), .cmd_o(cmd));

  sme_dp #(.DataDepth(DataDepth), .ReturnDepth(ReturnDepth), .VarCount(VarCount),
           .ProgDepth(ProgDepth)) u_dp (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i, .mode_i,
    .operand_i(operand_i), .cmd_i(cmd), .stat_o(stat), .next_pc_o, .status_o,
    .display_kind_o, .display_value_o(display_value_o), .depth_now_o);

`ifndef SYNTH
  // one command at a time
  a_cmd_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd.capture, cmd.div_start, cmd.exec, cmd.wr2})) else $error("cmd clash");
  // result appears right after the last write of the item
  a_exec_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((cmd.exec && !stat.need_swap) || cmd.wr2) |=> out_valid_o)
    else $error("no result after commit");
  // no item taken while a result waits unconsumed
  a_no_take: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |-> !in_ready_o) else $error("overrun");
`endif
endmodule
